FILE: rtl/dqhv_pkg.sv
// Types and constants shared by the DNS query header validator.
`default_nettype none

package dqhv_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 512;
    localparam int unsigned MAX_NAME_CHARS   = 255;
    localparam int unsigned HEADER_BYTES     = 12;

    // Configuration register indexes
    localparam logic CFG_MAX_QUERY_TYPE       = 1'b0;
    localparam logic CFG_REQUIRED_QUERY_CLASS = 1'b1;

    // Error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_FORMAT = 2'd2;
    localparam logic [1:0] ERR_COUNT  = 2'd3;

    // Verdict status codes
    localparam logic [1:0] ST_REQUEST_OK  = 2'd0;
    localparam logic [1:0] ST_RESPONSE_OK = 2'd1;
    localparam logic [1:0] ST_FORMAT_ERR  = 2'd2;
    localparam logic [1:0] ST_COUNT_ERR   = 2'd3;

    // Result kinds
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  name_char;
        logic [1:0]  status;
        logic [15:0] query_id;
        logic [15:0] query_type;
        logic [15:0] query_class;
        logic [7:0]  qname_len;
        logic        recursion_desired;
    } t_out;

endpackage

`default_nettype wire

FILE: rtl/dns_query_header_validator_core.sv
// DNS query header validator: header checks, question name and type/class parse.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready/i_in_data) carries one message byte per
//   transfer, with last_byte set on the final byte. Output channel
//   (o_out_valid/i_out_ready/o_out_data) carries zero or one result per byte:
//   a lowercased name character (or dot separator), or on the final byte the
//   verdict with status, id, type, class, name length and RD bit.
//   Path: a byte lands in the input register when it is transferred in, and the
//   parse logic then loads its result from there into the output register.
//   Throughput: one byte per cycle while the output register is not stalled.
//   Stall: while a result waits in the output register and i_out_ready is low,
//   one more byte is held in the input register and then o_in_ready drops.
//   Reset (i_rst_n low, synchronous) empties both registers, returns the parser
//   to the header phase and loads the configuration defaults (max type 16,
//   class 1). Configuration writes (i_cfg_we) take effect on the next cycle and
//   must only be issued while the block is idle.
`default_nettype none

module dns_query_header_validator_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output      logic           o_in_ready,
    input  wire dqhv_pkg::t_in  i_in_data,
    output      logic           o_out_valid,
    input  wire logic           i_out_ready,
    output      dqhv_pkg::t_out o_out_data,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_index,
    input  wire logic [15:0]    i_cfg_data
);

    localparam logic [2:0] PH_HEADER    = 3'd0;
    localparam logic [2:0] PH_LEN       = 3'd1;
    localparam logic [2:0] PH_CHARS     = 3'd2;
    localparam logic [2:0] PH_TYPECLASS = 3'd3;
    localparam logic [2:0] PH_TAIL      = 3'd4;
    localparam logic [2:0] PH_OVERLONG  = 3'd5;

    localparam logic [9:0] POS_MAX      = 10'd1023;
    localparam logic [9:0] POS_OVER     = 10'(dqhv_pkg::MAX_PACKET_BYTES - 1);
    localparam logic [9:0] POS_HDR      = 10'(dqhv_pkg::HEADER_BYTES);
    localparam logic [8:0] NAME_LIMIT   = 9'(dqhv_pkg::MAX_NAME_CHARS);

    // configuration
    logic [15:0] r_max_qtype;
    logic [15:0] r_req_qclass;

    // input register
    logic           r_in_valid;
    dqhv_pkg::t_in  r_in;

    // output register
    logic           r_out_valid;
    dqhv_pkg::t_out r_out;

    // parse state
    logic [9:0]  r_pos,    n_pos;
    logic [2:0]  r_phase,  n_phase;
    logic [15:0] r_hshift, n_hshift;
    logic [15:0] r_id,     n_id;
    logic [15:0] r_flags,  n_flags;
    logic [6:0]  r_lrem,   n_lrem;
    logic [7:0]  r_ncount, n_ncount;
    logic        r_first,  n_first;
    logic [31:0] r_tc,     n_tc;
    logic [1:0]  r_err,    n_err;

    logic           out_free;
    logic           proc_go;
    logic           res_valid;
    dqhv_pkg::t_out res;

    logic [7:0]  b;
    logic        last;
    logic        query;
    logic        alnum;
    logic        upper;
    logic [15:0] hs;
    logic [6:0]  lr;
    logic [8:0]  ncount_inc;
    logic        emit;
    logic [7:0]  ch;
    logic [1:0]  st;

    assign out_free    = !r_out_valid || i_out_ready;
    assign proc_go     = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        b          = r_in.packet_byte;
        last       = r_in.last_byte;
        query      = !r_flags[15];
        upper      = (b >= 8'h41) && (b <= 8'h5a);
        alnum      = ((b >= 8'h30) && (b <= 8'h39)) || upper ||
                     ((b >= 8'h61) && (b <= 8'h7a));
        hs         = {r_hshift[7:0], b};
        lr         = r_lrem + 7'd1;
        ncount_inc = {1'b0, r_ncount} + 9'd1;
        emit       = 1'b0;
        ch         = 8'h00;
        st         = dqhv_pkg::ST_REQUEST_OK;

        n_pos    = r_pos;
        n_phase  = r_phase;
        n_hshift = r_hshift;
        n_id     = r_id;
        n_flags  = r_flags;
        n_lrem   = r_lrem;
        n_ncount = r_ncount;
        n_first  = r_first;
        n_tc     = r_tc;
        n_err    = r_err;

        if (r_phase != PH_OVERLONG && r_pos >= POS_OVER && !last) begin
            n_phase = PH_OVERLONG;
        end

        unique case (n_phase)
            PH_HEADER: begin
                n_hshift = hs;
                if (r_pos == 10'd1) begin
                    n_id = hs;
                end else if (r_pos == 10'd3) begin
                    n_flags = hs;
                    // Z bit, then opcode of 2 or more
                    if (hs[6] || hs[14:11] >= 4'd2) begin
                        n_err = dqhv_pkg::ERR_FORMAT;
                    end
                end else if (r_pos == 10'd5) begin
                    if (hs != 16'd1 && n_err == dqhv_pkg::ERR_NONE) begin
                        n_err = dqhv_pkg::ERR_COUNT;
                    end
                end else if (r_pos == 10'd7 || r_pos == 10'd9) begin
                    if (query && hs != 16'd0 && n_err == dqhv_pkg::ERR_NONE) begin
                        n_err = dqhv_pkg::ERR_COUNT;
                    end
                end else if (r_pos == 10'd11) begin
                    if (query && r_flags[3:0] != 4'd0 && n_err == dqhv_pkg::ERR_NONE) begin
                        n_err = dqhv_pkg::ERR_FORMAT;
                    end
                    n_phase = (n_err != dqhv_pkg::ERR_NONE) ? PH_TAIL : PH_LEN;
                end
            end
            PH_LEN: begin
                if (b == 8'h00) begin
                    n_lrem  = 7'd0;
                    n_phase = PH_TYPECLASS;
                end else if (b[7] || (!r_first && ncount_inc > NAME_LIMIT)) begin
                    if (n_err == dqhv_pkg::ERR_NONE) begin
                        n_err = dqhv_pkg::ERR_FORMAT;
                    end
                    n_phase = PH_TAIL;
                end else begin
                    if (!r_first) begin
                        emit     = 1'b1;
                        ch       = 8'h2e;
                        n_ncount = ncount_inc[7:0];
                    end
                    n_first = 1'b0;
                    n_lrem  = b[6:0];
                    n_phase = PH_CHARS;
                end
            end
            PH_CHARS: begin
                if (!alnum || ncount_inc > NAME_LIMIT) begin
                    if (n_err == dqhv_pkg::ERR_NONE) begin
                        n_err = dqhv_pkg::ERR_FORMAT;
                    end
                    n_phase = PH_TAIL;
                end else begin
                    emit     = 1'b1;
                    ch       = upper ? (b + 8'h20) : b;
                    n_ncount = ncount_inc[7:0];
                    n_lrem   = r_lrem - 7'd1;
                    if (r_lrem == 7'd1) begin
                        n_phase = PH_LEN;
                    end
                end
            end
            PH_TYPECLASS: begin
                n_tc   = {r_tc[23:0], b};
                n_lrem = lr;
                if (lr >= 7'd4) begin
                    if ((n_tc[31:16] > r_max_qtype || n_tc[15:0] != r_req_qclass) &&
                        n_err == dqhv_pkg::ERR_NONE) begin
                        n_err = dqhv_pkg::ERR_FORMAT;
                    end
                    n_phase = PH_TAIL;
                end
            end
            default: begin
            end
        endcase

        n_pos = (r_pos < POS_MAX) ? (r_pos + 10'd1) : POS_MAX;

        priority if (n_phase == PH_OVERLONG || r_pos < POS_HDR) begin
            st = dqhv_pkg::ST_FORMAT_ERR;
        end else if (n_err != dqhv_pkg::ERR_NONE) begin
            st = n_err;
        end else if (n_phase != PH_TAIL) begin
            st = dqhv_pkg::ST_FORMAT_ERR;
        end else begin
            st = n_flags[15] ? dqhv_pkg::ST_RESPONSE_OK : dqhv_pkg::ST_REQUEST_OK;
        end

        res       = '0;
        res_valid = last || emit;
        if (last) begin
            res.item_kind         = dqhv_pkg::KIND_VERDICT;
            res.status            = st;
            res.query_id          = n_id;
            res.query_type        = n_tc[31:16];
            res.query_class       = n_tc[15:0];
            res.qname_len         = n_ncount;
            res.recursion_desired = n_flags[8];
            // message done: back to the header phase
            n_pos    = 10'd0;
            n_phase  = PH_HEADER;
            n_hshift = 16'd0;
            n_id     = 16'd0;
            n_flags  = 16'd0;
            n_lrem   = 7'd0;
            n_ncount = 8'd0;
            n_first  = 1'b1;
            n_tc     = 32'd0;
            n_err    = dqhv_pkg::ERR_NONE;
        end else begin
            res.item_kind = dqhv_pkg::KIND_CHAR;
            res.name_char = ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_qtype  <= 16'd16;
            r_req_qclass <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dqhv_pkg::CFG_MAX_QUERY_TYPE:       r_max_qtype  <= i_cfg_data;
                dqhv_pkg::CFG_REQUIRED_QUERY_CLASS: r_req_qclass <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc_go && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && res_valid) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 10'd0;
            r_phase  <= PH_HEADER;
            r_hshift <= 16'd0;
            r_id     <= 16'd0;
            r_flags  <= 16'd0;
            r_lrem   <= 7'd0;
            r_ncount <= 8'd0;
            r_first  <= 1'b1;
            r_tc     <= 32'd0;
            r_err    <= dqhv_pkg::ERR_NONE;
        end else if (proc_go) begin
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_hshift <= n_hshift;
            r_id     <= n_id;
            r_flags  <= n_flags;
            r_lrem   <= n_lrem;
            r_ncount <= n_ncount;
            r_first  <= n_first;
            r_tc     <= n_tc;
            r_err    <= n_err;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dqhv_checker.sv
// Port-level checker for the DNS query header validator, bound to the top level.
`default_nettype none

module dqhv_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_in_ready,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire dqhv_pkg::t_out o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output result changed while stalled");

    // character transfers carry nothing but the character
    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.item_kind == dqhv_pkg::KIND_CHAR |->
            o_out_data.status == 2'd0 && o_out_data.query_id == 16'd0 &&
            o_out_data.query_type == 16'd0 && o_out_data.query_class == 16'd0 &&
            o_out_data.qname_len == 8'd0 && !o_out_data.recursion_desired)
        else $error("character result with nonzero verdict fields");

    a_verdict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.item_kind == dqhv_pkg::KIND_VERDICT |->
            o_out_data.name_char == 8'h00)
        else $error("verdict with nonzero name character");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

endmodule

bind dns_query_header_validator_core dqhv_checker u_dqhv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
